FILE: design/ssbf_pkg.sv
// ssbf_pkg: shared constants and types for the subset-sum best-fill block.
// Used by ssbf_store and subset_sum_best_fill; depends on nothing else.

package ssbf_pkg;

    localparam int FILL_LIMIT   = 1023;
    localparam int WORD_BITS    = 64;   // power of two
    localparam int NUM_WORDS    = FILL_LIMIT / WORD_BITS + 1;

    localparam int WORD_LOG = $clog2(WORD_BITS);
    localparam int ADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CNT_W    = ADDR_W + 1;
    localparam int LVL_W    = ADDR_W + WORD_LOG;   // fill level as {word, bit}

    localparam int FILL_W = 10;
    localparam int VOL_W  = 12;
    localparam int CMP_W  = (LVL_W > FILL_W) ? LVL_W : FILL_W;
    localparam int VC_W   = (LVL_W > VOL_W) ? LVL_W : VOL_W;

    localparam logic [FILL_W-1:0] CAP_RESET = FILL_W'(1023);

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [ADDR_W-1:0]    waddr_t;
    typedef logic [LVL_W-1:0]     level_t;

    typedef struct packed {
        logic [VOL_W-1:0] item_volume;
        logic             last_item;
    } in_word_t;

    typedef struct packed {
        logic [FILL_W-1:0] best_fill;
        logic              set_done;
    } out_word_t;

    // store read request: own word and the shifted-source word
    typedef struct packed {
        waddr_t own_addr;
        logic   aux_en;
        waddr_t aux_addr;
    } rd_req_t;

    // store write request; clr drops every word back to the empty set
    typedef struct packed {
        logic   en;
        waddr_t addr;
        word_t  data;
        logic   clr;
    } wr_req_t;

endpackage

FILE: design/ssbf_store.sv
// ssbf_store: reachable-level bitset, NUM_WORDS words, two registered read ports.
// Per-word valid flags give the empty set (only fill zero) without a sweep.
// Depends on ssbf_pkg.

module ssbf_store
(
    input  logic             clk,
    input  logic             rst_n,
    input  ssbf_pkg::rd_req_t rd,
    input  ssbf_pkg::wr_req_t wr,
    output ssbf_pkg::word_t  own_data,
    output ssbf_pkg::word_t  aux_data
);

    ssbf_pkg::word_t              mem [ssbf_pkg::NUM_WORDS];
    logic [ssbf_pkg::NUM_WORDS-1:0] valid_reg;
    ssbf_pkg::word_t              own_reg;
    ssbf_pkg::word_t              aux_reg;

    // value of a word that was never written in this set
    function automatic ssbf_pkg::word_t empty_word(input ssbf_pkg::waddr_t a);
        empty_word = (a == '0) ? ssbf_pkg::word_t'(1) : '0;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.clr)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        own_reg <= valid_reg[rd.own_addr] ? mem[rd.own_addr] : empty_word(rd.own_addr);
        if (!rd.aux_en)
        begin
            aux_reg <= '0;
        end
        else
        begin
            aux_reg <= valid_reg[rd.aux_addr] ? mem[rd.aux_addr]
                                              : empty_word(rd.aux_addr);
        end
    end

    assign own_data = own_reg;
    assign aux_data = aux_reg;

endmodule

FILE: design/subset_sum_best_fill.sv
// subset_sum_best_fill: 0/1 knapsack by volume as a subset-sum bitset.
// Top level: control sequencer, word-serial update datapath, best-fill search.
// Depends on ssbf_pkg and ssbf_store.
//
// Usage:
//   Input channel in_valid/in_stall/in_word carries one item word (volume and
//   last-item flag). Output channel out_valid/out_stall/out_word returns one
//   result word per item: best fill not above capacity, and set_done.
//   cfg_we/cfg_wdata writes the capacity register; write it only while idle.
// Operation:
//   The reachable set is held as NUM_WORDS words of WORD_BITS bits (16 x 64)
//   and one word is read, shifted and merged per cycle, highest word first,
//   after one priming read. A result is formed once the lowest word has left
//   the search stage and waits in a pending register until the output register
//   is free; the next item is taken only after the result has moved to the
//   output register.
// Reset:
//   Capacity goes to 1023, the set holds only fill zero, both channels idle.
//   A last item empties the set again right after its result is formed.
// Stall:
//   out_word holds while out_stall is high; one further finished result can
//   wait inside, and in_stall stays high until it has moved out.

module subset_sum_best_fill
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  ssbf_pkg::in_word_t              in_word,
    output logic                            out_valid,
    input  logic                            out_stall,
    output ssbf_pkg::out_word_t             out_word,
    input  logic                            cfg_we,
    input  logic [ssbf_pkg::FILL_W-1:0]     cfg_wdata
);

    typedef enum logic [1:0] {
        IDLE,
        RUN,
        WAIT_OUT
    } state_t;

    localparam int SI_W = ssbf_pkg::ADDR_W + 2;

    state_t                           state_reg;
    logic [ssbf_pkg::CNT_W-1:0]       cnt_reg;
    logic [ssbf_pkg::FILL_W-1:0]      capacity_reg;

    // item held for the whole pass
    logic                             upd_en_reg;
    ssbf_pkg::waddr_t                 koff_reg;
    logic [ssbf_pkg::WORD_LOG-1:0]    rsh_reg;
    logic                             last_reg;

    // stage 1: store data back, merge
    logic                             s1_vld_reg;
    logic                             s1_prime_reg;
    ssbf_pkg::waddr_t                 s1_word_reg;
    ssbf_pkg::word_t                  hi_hold_reg;

    // stage 2: search
    logic                             s2_vld_reg;
    ssbf_pkg::waddr_t                 s2_word_reg;
    ssbf_pkg::word_t                  s2_data_reg;

    logic                             found_reg;
    ssbf_pkg::level_t                 best_reg;
    ssbf_pkg::out_word_t              pend_reg;
    ssbf_pkg::out_word_t              out_reg;
    logic                             out_valid_reg;

    ssbf_pkg::rd_req_t                rd;
    ssbf_pkg::wr_req_t                wr;
    ssbf_pkg::word_t                  own_data;
    ssbf_pkg::word_t                  aux_data;

    ssbf_pkg::level_t                 cap_eff;
    logic [ssbf_pkg::CMP_W-1:0]       cap_wide;
    logic                             vol_ok;
    logic                             in_take;
    logic                             out_take;
    logic                             issue;
    logic signed [SI_W-1:0]           aux_idx;
    logic [2*ssbf_pkg::WORD_BITS-1:0] pair;
    ssbf_pkg::word_t                  shifted;
    ssbf_pkg::word_t                  lvl_mask;
    ssbf_pkg::word_t                  merged;
    logic [ssbf_pkg::ADDR_W-1:0]      cap_word;
    logic [ssbf_pkg::WORD_LOG-1:0]    cap_bit;
    logic                             fin;
    ssbf_pkg::level_t                 best_next;

    function automatic logic [ssbf_pkg::WORD_LOG-1:0] top_bit(input ssbf_pkg::word_t d);
        logic [ssbf_pkg::WORD_LOG-1:0] idx;
        idx = '0;
        for (int b = 0; b < ssbf_pkg::WORD_BITS; b++)
        begin
            if (d[b])
            begin
                idx = ssbf_pkg::WORD_LOG'(b);
            end
        end
        top_bit = idx;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= ssbf_pkg::CAP_RESET;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_wdata;
        end
    end

    assign cap_wide = ssbf_pkg::CMP_W'(capacity_reg);
    assign cap_eff  = (cap_wide > ssbf_pkg::CMP_W'(ssbf_pkg::FILL_LIMIT))
                    ? ssbf_pkg::LVL_W'(ssbf_pkg::FILL_LIMIT)
                    : ssbf_pkg::LVL_W'(cap_wide);
    assign cap_word = cap_eff[ssbf_pkg::LVL_W-1:ssbf_pkg::WORD_LOG];
    assign cap_bit  = cap_eff[ssbf_pkg::WORD_LOG-1:0];

    assign vol_ok = (in_word.item_volume != '0) &&
                    (ssbf_pkg::VC_W'(in_word.item_volume) <= ssbf_pkg::VC_W'(cap_eff));

    assign in_stall  = (state_reg != IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    // issue: cnt 0 primes the high source word, cnt 1..N reads word N-cnt
    assign issue   = (state_reg == RUN) && (cnt_reg <= ssbf_pkg::CNT_W'(ssbf_pkg::NUM_WORDS));
    assign aux_idx = $signed(SI_W'(ssbf_pkg::NUM_WORDS - 1))
                   - $signed({2'b00, koff_reg})
                   - $signed({1'b0, cnt_reg});

    always_comb
    begin
        rd.own_addr = ssbf_pkg::ADDR_W'(ssbf_pkg::CNT_W'(ssbf_pkg::NUM_WORDS) - cnt_reg);
        rd.aux_en   = !aux_idx[SI_W-1];
        rd.aux_addr = aux_idx[ssbf_pkg::ADDR_W-1:0];
    end

    // source bits for level s are at level s - volume
    assign pair    = {hi_hold_reg, aux_data} << rsh_reg;
    assign shifted = pair[2*ssbf_pkg::WORD_BITS-1:ssbf_pkg::WORD_BITS];

    always_comb
    begin
        if (s1_word_reg < cap_word)
        begin
            lvl_mask = '1;
        end
        else if (s1_word_reg == cap_word)
        begin
            lvl_mask = (ssbf_pkg::word_t'(2) << cap_bit) - ssbf_pkg::word_t'(1);
        end
        else
        begin
            lvl_mask = '0;
        end
    end

    assign merged = own_data | (shifted & lvl_mask & {ssbf_pkg::WORD_BITS{upd_en_reg}});

    assign fin = s2_vld_reg && (s2_word_reg == '0);

    always_comb
    begin
        wr.en   = s1_vld_reg && !s1_prime_reg;
        wr.addr = s1_word_reg;
        wr.data = merged;
        wr.clr  = fin && last_reg;
    end

    always_comb
    begin
        if (found_reg)
        begin
            best_next = best_reg;
        end
        else if (s2_vld_reg && (s2_data_reg != '0))
        begin
            best_next = {s2_word_reg, top_bit(s2_data_reg)};
        end
        else
        begin
            best_next = '0;
        end
    end

    ssbf_store u_store
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd       (rd),
        .wr       (wr),
        .own_data (own_data),
        .aux_data (aux_data)
    );

    // pipeline behind the store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg   <= 1'b0;
            s1_prime_reg <= 1'b0;
            s2_vld_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg   <= issue;
            s1_prime_reg <= issue && (cnt_reg == '0);
            s2_vld_reg   <= s1_vld_reg && !s1_prime_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_word_reg <= rd.own_addr;
        if (s1_vld_reg)
        begin
            hi_hold_reg <= aux_data;
        end
        s2_word_reg <= s1_word_reg;
        s2_data_reg <= merged & lvl_mask;
        if (in_take)
        begin
            upd_en_reg <= vol_ok;
            koff_reg   <= ssbf_pkg::ADDR_W'(in_word.item_volume >> ssbf_pkg::WORD_LOG);
            rsh_reg    <= in_word.item_volume[ssbf_pkg::WORD_LOG-1:0];
            last_reg   <= in_word.last_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            best_reg      <= '0;
            pend_reg      <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // in WAIT_OUT the output register is reloaded below instead
            if (out_take && (state_reg != WAIT_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE:
                begin
                    if (in_take)
                    begin
                        state_reg <= RUN;
                        cnt_reg   <= '0;
                        found_reg <= 1'b0;
                    end
                end
                RUN:
                begin
                    if (issue)
                    begin
                        cnt_reg <= cnt_reg + ssbf_pkg::CNT_W'(1);
                    end
                    best_reg  <= best_next;
                    found_reg <= found_reg || (s2_vld_reg && (s2_data_reg != '0));
                    if (fin)
                    begin
                        pend_reg.best_fill <= ssbf_pkg::FILL_W'(best_next);
                        pend_reg.set_done  <= last_reg;
                        state_reg          <= WAIT_OUT;
                    end
                end
                WAIT_OUT:
                begin
                    if (!out_valid_reg || out_take)
                    begin
                        out_reg       <= pend_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

FILE: verif/tb_subset_sum_best_fill.sv
// tb_subset_sum_best_fill: self-checking testbench for the subset-sum best-fill block.
// It drives a directed table then random item sets and checks every result word against
// a bitset predictor or a known table value. Depends on ssbf_pkg, subset_sum_best_fill.

module tb_subset_sum_best_fill;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_DIRECTED    = 24;
    localparam int N_PHASES      = 9;
    localparam int ITEMS_PER_PH  = 205;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 40;
    localparam int N_LEVELS      = ssbf_pkg::FILL_LIMIT + 1;

    typedef logic [N_LEVELS-1:0] levels_t;

    typedef struct packed {
        logic [ssbf_pkg::VOL_W-1:0]  vol;
        logic                        is_last;
        logic                        cap_write;
        logic [ssbf_pkg::FILL_W-1:0] cap_value;
        logic                        known;
        logic [ssbf_pkg::FILL_W-1:0] exp_best;
    } dir_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    ssbf_pkg::in_word_t          in_word;
    logic                        out_valid;
    logic                        out_stall;
    ssbf_pkg::out_word_t         out_word;
    logic                        cfg_we;
    logic [ssbf_pkg::FILL_W-1:0] cfg_wdata;

    // predictor state
    levels_t                     fill_levels;
    logic [ssbf_pkg::FILL_W-1:0] capacity_r;
    ssbf_pkg::out_word_t         fill_q[$];

    int  err_count;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_req;

    // vol, last, cap write, cap value, expectation known, expected best
    dir_row_t directed_rows [0:N_DIRECTED-1] = '{
        '{12'd0,    1'b0, 1'b0, 10'd0,    1'b1, 10'd0},
        '{12'd4095, 1'b0, 1'b0, 10'd0,    1'b1, 10'd0},
        '{12'd1024, 1'b0, 1'b0, 10'd0,    1'b1, 10'd0},
        '{12'd1023, 1'b0, 1'b0, 10'd0,    1'b1, 10'd1023},
        '{12'd1,    1'b1, 1'b0, 10'd0,    1'b1, 10'd1023},
        '{12'd1,    1'b1, 1'b0, 10'd0,    1'b1, 10'd1},
        '{12'd0,    1'b0, 1'b1, 10'd0,    1'b1, 10'd0},
        '{12'd1,    1'b0, 1'b0, 10'd0,    1'b1, 10'd0},
        '{12'd2048, 1'b1, 1'b0, 10'd0,    1'b1, 10'd0},
        '{12'd1,    1'b0, 1'b1, 10'd1,    1'b1, 10'd1},
        '{12'd1,    1'b1, 1'b0, 10'd0,    1'b1, 10'd1},
        '{12'd30,   1'b0, 1'b1, 10'd100,  1'b0, 10'd0},
        '{12'd45,   1'b0, 1'b0, 10'd0,    1'b0, 10'd0},
        '{12'd50,   1'b0, 1'b0, 10'd0,    1'b0, 10'd0},
        '{12'd5,    1'b0, 1'b1, 10'd1023, 1'b0, 10'd0},
        '{12'd1,    1'b0, 1'b1, 10'd60,   1'b0, 10'd0},
        '{12'd3,    1'b1, 1'b0, 10'd0,    1'b0, 10'd0},
        '{12'd512,  1'b0, 1'b1, 10'd1023, 1'b1, 10'd512},
        '{12'd511,  1'b0, 1'b0, 10'd0,    1'b1, 10'd1023},
        '{12'd4095, 1'b1, 1'b0, 10'd0,    1'b1, 10'd1023},
        '{12'd64,   1'b0, 1'b0, 10'd0,    1'b0, 10'd0},
        '{12'd128,  1'b0, 1'b0, 10'd0,    1'b0, 10'd0},
        '{12'd1365, 1'b0, 1'b0, 10'd0,    1'b0, 10'd0},
        '{12'd2730, 1'b1, 1'b0, 10'd0,    1'b0, 10'd0}
    };

    logic [ssbf_pkg::FILL_W-1:0] phase_caps [0:N_PHASES-1] = '{
        10'd1023, 10'd0, 10'd517, 10'd15, 10'd1, 10'd1000, 10'd0, 10'd63, 10'd64
    };

    subset_sum_best_fill DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        #50_000_000;
        $display("FAIL subset_sum_best_fill");
        $finish;
    end

    // Add one item to the reachable set and return the best fill it leaves.
    function automatic ssbf_pkg::out_word_t next_fill(input ssbf_pkg::in_word_t w);
        int                  cap;
        int                  vol;
        levels_t             cap_mask;
        ssbf_pkg::out_word_t r;
        cap = (int'(capacity_r) > ssbf_pkg::FILL_LIMIT) ? ssbf_pkg::FILL_LIMIT
                                                        : int'(capacity_r);
        vol = int'(w.item_volume);
        cap_mask = {N_LEVELS{1'b1}} >> (ssbf_pkg::FILL_LIMIT - cap);
        if (vol > 0 && vol <= cap)
        begin
            fill_levels = fill_levels | ((fill_levels << vol) & cap_mask);
        end
        r.best_fill = '0;
        for (int s = cap; s >= 0; s--)
        begin
            if (fill_levels[s])
            begin
                r.best_fill = ssbf_pkg::FILL_W'(s);
                break;
            end
        end
        r.set_done = w.last_item;
        if (w.last_item)
        begin
            fill_levels = levels_t'(1);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, exp_val);
        err_count++;
    endtask

    // Offer one word and return at the edge where it is taken.
    task automatic send_item(input ssbf_pkg::in_word_t w);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_and_predict(input ssbf_pkg::in_word_t w, input bit known,
                                    input logic [ssbf_pkg::FILL_W-1:0] exp_best);
        ssbf_pkg::out_word_t r;
        send_item(w);
        r = next_fill(w);
        if (known)
        begin
            r.best_fill = exp_best;
        end
        fill_q.push_back(r);
    endtask

    // Capacity changes only with the block idle.
    task automatic set_capacity(input logic [ssbf_pkg::FILL_W-1:0] c);
        in_valid <= 1'b0;
        @(posedge clk);
        while (fill_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_we     <= 1'b0;
        capacity_r  = c;
    endtask

    function automatic logic [ssbf_pkg::VOL_W-1:0] pick_volume(input int cap);
        int r;
        r = $urandom_range(99);
        if (r < 65)
        begin
            return ssbf_pkg::VOL_W'($urandom_range(cap, 0));
        end
        else if (r < 80)
        begin
            return ssbf_pkg::VOL_W'($urandom_range(cap / 4, 0));
        end
        else if (r < 90)
        begin
            return ssbf_pkg::VOL_W'($urandom_range(4095, 0));
        end
        return ssbf_pkg::VOL_W'($urandom_range(4095, cap + 1));
    endfunction

    // receiver: random stall, long hold on request, result check
    initial
    begin
        int                  hold_left;
        ssbf_pkg::out_word_t exp_w;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (fill_q.size() == 0)
                begin
                    report_mismatch("unexpected result word, best_fill", out_word.best_fill, -1);
                end
                else
                begin
                    exp_w = fill_q.pop_front();
                    if (out_word.best_fill !== exp_w.best_fill)
                    begin
                        report_mismatch("best_fill", out_word.best_fill, exp_w.best_fill);
                    end
                    if (out_word.set_done !== exp_w.set_done)
                    begin
                        report_mismatch("set_done", out_word.set_done, exp_w.set_done);
                    end
                end
            end
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial
    begin
        ssbf_pkg::in_word_t w;
        int                 set_left;
        err_count     = 0;
        send_idle_pct = 32;
        recv_idle_pct = 69;
        hold_req      = 1'b0;
        fill_levels   = levels_t'(1);
        capacity_r    = ssbf_pkg::CAP_RESET;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_word   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (directed_rows[i].cap_write)
            begin
                set_capacity(directed_rows[i].cap_value);
            end
            w.item_volume = directed_rows[i].vol;
            w.last_item   = directed_rows[i].is_last;
            send_and_predict(w, directed_rows[i].known, directed_rows[i].exp_best);
        end

        // random sets; a set may run across a capacity change
        set_left = 0;
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph == 6)
            begin
                set_capacity(ssbf_pkg::FILL_W'($urandom_range(1022, 2)));
            end
            else
            begin
                set_capacity(phase_caps[ph]);
            end
            unique case (ph / 3)
                0:
                begin
                    send_idle_pct = 32;
                    recv_idle_pct = 69;
                end
                1:
                begin
                    send_idle_pct = 69;
                    recv_idle_pct = 32;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (ph == 6)
            begin
                hold_req = 1'b1;
            end
            for (int k = 0; k < ITEMS_PER_PH; k++)
            begin
                if (set_left == 0)
                begin
                    set_left = ($urandom_range(9) == 0) ? $urandom_range(40, 1)
                                                          : $urandom_range(12, 1);
                end
                set_left--;
                w.item_volume = pick_volume(int'(capacity_r));
                // a few sets are cut short at random
                w.last_item   = (set_left == 0) || ($urandom_range(49) == 0);
                if (w.last_item)
                begin
                    set_left = 0;
                end
                send_and_predict(w, 1'b0, '0);
            end
        end
        in_valid <= 1'b0;

        while (fill_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
        begin
            $display("PASS subset_sum_best_fill");
        end
        else
        begin
            $display("FAIL subset_sum_best_fill");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/ssbf_pkg.sv
design/ssbf_store.sv
design/subset_sum_best_fill.sv
verif/tb_subset_sum_best_fill.sv
